// ===== rtl/fcal_pkg.sv =====
// Shared constants, types and value conversions for the fixed-capacity array list.
package fcal_pkg;

    // Sizes of the list and of its fields.
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ACT_W       = 3;
    localparam int POS_W       = 10;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;

    // Action codes carried by a request.
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SWAP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd4;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    // One cycle's access to the element memory.
    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]      raddr;
    } t_mem_req;

    // Sign-extend a 32-bit input value and cut it to the stored width.
    function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic [DATA_W-1:0] v);
        logic [63:0] ext;
        ext = {{(64 - DATA_W){v[DATA_W-1]}}, v};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    // Sign-extend a stored entry and cut it to the 32-bit result field.
    function automatic logic [DATA_W-1:0] from_stored(input logic [VALUE_WIDTH-1:0] s);
        logic [63:0] ext;
        ext = 64'(signed'(s));
        return ext[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/fcal_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fcal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fcal_ctrl.sv =====
// Sequencer that carries out each list action on the element memory and holds the result.
module fcal_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fcal_pkg::ACT_W-1:0]      i_action,
    input  logic [fcal_pkg::POS_W-1:0]      i_position,
    input  logic [fcal_pkg::POS_W-1:0]      i_second_position,
    input  logic [fcal_pkg::DATA_W-1:0]     i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fcal_pkg::STATUS_W-1:0]   o_status,
    output logic [fcal_pkg::DATA_W-1:0]     o_read_value,
    output logic [fcal_pkg::POS_W-1:0]      o_found_index,
    output logic [fcal_pkg::CNT_W-1:0]      o_element_count,
    output fcal_pkg::t_mem_req              o_mem_req,
    input  logic [fcal_pkg::VALUE_WIDTH-1:0] i_mem_rdata
);
    import fcal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT,
        S_INSERT,
        S_MOVE,
        S_GET,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C,
        S_FIND,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      r_pos2, n_pos2;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [VALUE_WIDTH-1:0] r_tmp, n_tmp;
    logic [ADDR_W-1:0]     r_ra, n_ra;
    logic [STATUS_W-1:0]   r_st, n_st;
    logic [DATA_W-1:0]     r_rd, n_rd;
    logic [POS_W-1:0]      r_fi, n_fi;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [DATA_W-1:0]     r_out_rd, n_out_rd;
    logic [POS_W-1:0]      r_out_fi, n_out_fi;
    logic [CNT_W-1:0]      r_out_cnt, n_out_cnt;

    logic                  accept_in;
    logic                  out_take;
    logic [CNT_W-1:0]      pos_ext;
    logic [CNT_W-1:0]      pos2_ext;
    logic [CNT_W-1:0]      count_m1;
    t_mem_req              mem_req;

    assign accept_in = i_in_valid && (r_state == S_IDLE);
    assign out_take  = r_out_valid && !i_out_stall;
    assign pos_ext   = CNT_W'(i_position);
    assign pos2_ext  = CNT_W'(i_second_position);
    assign count_m1  = r_count - CNT_W'(1);

    // Next-state logic and memory access for every step of an action.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_pos2       = r_pos2;
        n_val        = r_val;
        n_tmp        = r_tmp;
        n_ra         = r_ra;
        n_st         = r_st;
        n_rd         = r_rd;
        n_fi         = r_fi;
        n_out_valid  = out_take ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_rd     = r_out_rd;
        n_out_fi     = r_out_fi;
        n_out_cnt    = r_out_cnt;
        mem_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_pos   = i_position;
                    n_pos2  = i_second_position;
                    n_val   = to_stored(i_value);
                    n_st    = ST_OK;
                    n_rd    = '0;
                    n_fi    = '0;
                    n_state = S_DONE;
                    unique case (i_action)
                        ACT_INSERT: begin
                            if (pos_ext > r_count) begin
                                n_st = ST_BAD_POS;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else if (pos_ext == r_count) begin
                                // Append: no entries to shift.
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ADDR_W'(i_position);
                                mem_req.wdata = to_stored(i_value);
                                n_count       = r_count + CNT_W'(1);
                            end else begin
                                mem_req.raddr = ADDR_W'(count_m1);
                                n_ra          = ADDR_W'(count_m1);
                                n_state       = S_SHIFT;
                            end
                        end
                        ACT_REMOVE: begin
                            if (pos_ext >= r_count) begin
                                n_st = ST_BAD_POS;
                            end else if (pos_ext == count_m1) begin
                                // Removing the last entry only shrinks the list.
                                n_count = count_m1;
                            end else begin
                                mem_req.raddr = ADDR_W'(count_m1);
                                n_state       = S_MOVE;
                            end
                        end
                        ACT_GET: begin
                            if (pos_ext >= r_count) begin
                                n_st = ST_BAD_POS;
                            end else begin
                                mem_req.raddr = ADDR_W'(i_position);
                                n_state       = S_GET;
                            end
                        end
                        ACT_SWAP: begin
                            if (pos_ext >= r_count || pos2_ext >= r_count) begin
                                n_st = ST_BAD_POS;
                            end else begin
                                mem_req.raddr = ADDR_W'(i_position);
                                n_state       = S_SWAP_A;
                            end
                        end
                        ACT_FIND: begin
                            if (r_count == '0) begin
                                n_st = ST_NO_MATCH;
                            end else begin
                                mem_req.raddr = '0;
                                n_ra          = '0;
                                n_state       = S_FIND;
                            end
                        end
                        default: begin
                            n_st = ST_OK;
                        end
                    endcase
                end
            end

            // Move one entry up per cycle, reading the next one down meanwhile.
            S_SHIFT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ra + ADDR_W'(1);
                mem_req.wdata = i_mem_rdata;
                if (r_ra == ADDR_W'(r_pos)) begin
                    n_state = S_INSERT;
                end else begin
                    mem_req.raddr = r_ra - ADDR_W'(1);
                    n_ra          = r_ra - ADDR_W'(1);
                end
            end

            S_INSERT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(r_pos);
                mem_req.wdata = r_val;
                n_count       = r_count + CNT_W'(1);
                n_state       = S_DONE;
            end

            // The last entry fills the removed slot.
            S_MOVE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(r_pos);
                mem_req.wdata = i_mem_rdata;
                n_count       = count_m1;
                n_state       = S_DONE;
            end

            S_GET: begin
                n_rd    = from_stored(i_mem_rdata);
                n_state = S_DONE;
            end

            S_SWAP_A: begin
                n_tmp         = i_mem_rdata;
                mem_req.raddr = ADDR_W'(r_pos2);
                n_state       = S_SWAP_B;
            end

            S_SWAP_B: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(r_pos);
                mem_req.wdata = i_mem_rdata;
                n_state       = S_SWAP_C;
            end

            S_SWAP_C: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(r_pos2);
                mem_req.wdata = r_tmp;
                n_state       = S_DONE;
            end

            // Linear scan from the bottom; stops at the first match.
            S_FIND: begin
                if (i_mem_rdata == r_val) begin
                    n_fi    = POS_W'(r_ra);
                    n_state = S_DONE;
                end else if (CNT_W'(r_ra) + CNT_W'(1) == r_count) begin
                    n_st    = ST_NO_MATCH;
                    n_state = S_DONE;
                end else begin
                    mem_req.raddr = r_ra + ADDR_W'(1);
                    n_ra          = r_ra + ADDR_W'(1);
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_st;
                    n_out_rd     = r_rd;
                    n_out_fi     = r_fi;
                    n_out_cnt    = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_pos2       <= n_pos2;
        r_val        <= n_val;
        r_tmp        <= n_tmp;
        r_ra         <= n_ra;
        r_st         <= n_st;
        r_rd         <= n_rd;
        r_fi         <= n_fi;
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_fi     <= n_out_fi;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_read_value    = r_out_rd;
    assign o_found_index   = r_out_fi;
    assign o_element_count = r_out_cnt;
    assign o_mem_req       = mem_req;

endmodule

// ===== rtl/fixed_capacity_array_list_unit.sv =====
// Top level of the fixed-capacity array list: sequencer plus element memory.
//
// The list holds up to 1024 signed 32-bit entries in a single RAM with one
// write and one registered read port, and works on one request at a time.
// Invalid or full requests, unused action codes, appends and removal of the
// last entry need no memory read and go straight to the result; get, remove
// and swap first read the memory; insert below the end first moves every
// entry from the end down to the position up by one; find reads from index 0
// up to the first match or the end of the list. The memory port pair shapes
// this: inserts move one entry per cycle and find checks one entry per
// cycle, so the worst case is about one pass over the store.
// The next request is taken once the current one has handed over its result;
// an unclaimed result waits in the output register and holds back the next
// result in turn. The memory needs no clearing pass after reset.
module fixed_capacity_array_list_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fcal_pkg::ACT_W-1:0]      i_action,
    input  logic [fcal_pkg::POS_W-1:0]      i_position,
    input  logic [fcal_pkg::POS_W-1:0]      i_second_position,
    input  logic signed [fcal_pkg::DATA_W-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fcal_pkg::STATUS_W-1:0]   o_status,
    output logic signed [fcal_pkg::DATA_W-1:0] o_read_value,
    output logic [fcal_pkg::POS_W-1:0]      o_found_index,
    output logic [fcal_pkg::CNT_W-1:0]      o_element_count,
    output logic                            o_is_empty,
    output logic                            o_is_full
);
    import fcal_pkg::*;

    t_mem_req               mem_req;
    logic [VALUE_WIDTH-1:0] mem_rdata;
    logic [DATA_W-1:0]      read_value;

    // Action sequencer with the result register.
    fcal_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_read_value      (read_value),
        .o_found_index     (o_found_index),
        .o_element_count   (o_element_count),
        .o_mem_req         (mem_req),
        .i_mem_rdata       (mem_rdata)
    );

    // Element store.
    fcal_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Flags follow the count held with the result.
    assign o_read_value = signed'(read_value);
    assign o_is_empty   = (o_element_count == '0);
    assign o_is_full    = (o_element_count == CNT_W'(CAPACITY));

endmodule

// ===== test/fixed_capacity_array_list_checker.sv =====
// Scoreboard for the fixed-capacity array list: predicts every result and checks it in order.
`timescale 1ns / 1ps
module fixed_capacity_array_list_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [fcal_pkg::ACT_W-1:0]      i_action,
    input  logic [fcal_pkg::POS_W-1:0]      i_position,
    input  logic [fcal_pkg::POS_W-1:0]      i_second_position,
    input  logic [fcal_pkg::DATA_W-1:0]     i_value,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [fcal_pkg::STATUS_W-1:0]   i_status,
    input  logic [fcal_pkg::DATA_W-1:0]     i_read_value,
    input  logic [fcal_pkg::POS_W-1:0]      i_found_index,
    input  logic [fcal_pkg::CNT_W-1:0]      i_element_count,
    input  logic                            i_is_empty,
    input  logic                            i_is_full,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results_checked,
    output int                              o_peak_count
);
    import fcal_pkg::*;

    // Only the first few mismatches are printed; all of them are counted.
    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [POS_W-1:0]    found_index;
        logic [CNT_W-1:0]    count;
        logic                empty;
        logic                full;
    } t_list_result;

    // Our own copy of the list contents and its length.
    logic [VALUE_WIDTH-1:0] list_entries [CAPACITY];
    logic [CNT_W-1:0]       list_length;
    t_list_result           awaited_results[$];
    int                     mismatches_reported = 0;

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_results_checked = 0;
        o_peak_count      = 0;
    end

    // Apply one request to the copy of the list and return the result it should give.
    function automatic t_list_result apply_list_request(input logic [ACT_W-1:0] act,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [POS_W-1:0] pos2,
                                                        input logic [DATA_W-1:0] val);
        t_list_result           res;
        logic [VALUE_WIDTH-1:0] stored_val;
        logic [VALUE_WIDTH-1:0] held;
        int                     n;
        int                     i;
        res        = '0;
        res.status = ST_OK;
        n          = int'(list_length);
        stored_val = VALUE_WIDTH'(signed'(val));
        case (act)
            ACT_INSERT: begin
                // A bad position wins over a full list.
                if (int'(pos) > n || int'(pos) >= CAPACITY) begin
                    res.status = ST_BAD_POS;
                end else if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = n; i > int'(pos); i--) begin
                        list_entries[i] = list_entries[i-1];
                    end
                    list_entries[pos] = stored_val;
                    list_length       = CNT_W'(n + 1);
                end
            end
            ACT_REMOVE: begin
                // The last entry fills the hole.
                if (int'(pos) >= n) begin
                    res.status = ST_BAD_POS;
                end else begin
                    list_entries[pos] = list_entries[n-1];
                    list_length       = CNT_W'(n - 1);
                end
            end
            ACT_GET: begin
                if (int'(pos) >= n) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.read_value = DATA_W'(signed'(list_entries[pos]));
                end
            end
            ACT_SWAP: begin
                if (int'(pos) >= n || int'(pos2) >= n) begin
                    res.status = ST_BAD_POS;
                end else begin
                    held               = list_entries[pos];
                    list_entries[pos]  = list_entries[pos2];
                    list_entries[pos2] = held;
                end
            end
            ACT_FIND: begin
                res.status = ST_NO_MATCH;
                for (i = 0; i < n; i++) begin
                    if (list_entries[i] == stored_val) begin
                        res.status      = ST_OK;
                        res.found_index = POS_W'(i);
                        break;
                    end
                end
            end
            default: begin
                // Unused action codes leave everything as it was.
            end
        endcase
        res.count = list_length;
        res.empty = (list_length == '0);
        res.full  = (list_length == CNT_W'(CAPACITY));
        return res;
    endfunction

    // Report a differing field; returns 1 when the field is wrong.
    function automatic bit field_differs(input string field, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
        if (want === got) begin
            return 1'b0;
        end
        if (mismatches_reported < REPORT_LIMIT) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end else if (mismatches_reported == REPORT_LIMIT) begin
            $display("Further mismatches are counted but not printed.");
        end
        mismatches_reported++;
        return 1'b1;
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin : scoreboard
        t_list_result want;
        bit           bad;
        if (!i_rst_n) begin
            list_length = '0;
            awaited_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_list_request(i_action, i_position,
                                                             i_second_position, i_value));
                if (int'(list_length) > o_peak_count) begin
                    o_peak_count = int'(list_length);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result arrived with no request outstanding (status %0d)",
                           i_status);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("status", DATA_W'(want.status),
                                         DATA_W'(i_status));
                    bad |= field_differs("read_value", want.read_value, i_read_value);
                    bad |= field_differs("found_index", DATA_W'(want.found_index),
                                         DATA_W'(i_found_index));
                    bad |= field_differs("element_count", DATA_W'(want.count),
                                         DATA_W'(i_element_count));
                    bad |= field_differs("is_empty", DATA_W'(want.empty),
                                         DATA_W'(i_is_empty));
                    bad |= field_differs("is_full", DATA_W'(want.full),
                                         DATA_W'(i_is_full));
                    if (bad) begin
                        o_fail_count++;
                    end
                    o_results_checked++;
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ===== test/fixed_capacity_array_list_unit_tb.sv =====
// Top of the fixed-capacity array list test: clock, reset, request and stall drivers, verdict.
`timescale 1ns / 1ps
module fixed_capacity_array_list_unit_tb;
    import fcal_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_PER_PHASE = 136;
    localparam int HOLD_OFF_CYCLES  = 500;
    localparam int QUIET_LIMIT      = 12000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int POOL_DEPTH       = 64;
    localparam int SMALL_LIST       = 160;
    localparam logic [ACT_W-1:0] ACT_LAST = '1;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_stall;
    logic [ACT_W-1:0]    i_action          = ACT_GET;
    logic [POS_W-1:0]    i_position        = '0;
    logic [POS_W-1:0]    i_second_position = '0;
    logic [DATA_W-1:0]   i_value           = '0;
    logic                o_out_valid;
    logic                i_out_stall       = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_read_value;
    logic [POS_W-1:0]    o_found_index;
    logic [CNT_W-1:0]    o_element_count;
    logic                o_is_empty;
    logic                o_is_full;

    int fail_count;
    int pending_results;
    int results_checked;
    int peak_length;

    // Stimulus shaping: idle and stall rates, the hold-off request, a rough list length.
    int                idle_pct      = 0;
    int                stall_pct     = 0;
    int                hold_requests = 0;
    int                hold_served   = 0;
    int                hold_left     = 0;
    int                list_len      = 0;
    int                quiet_cycles  = 0;
    int                sent_per_action [8];
    logic [DATA_W-1:0] value_pool[$];

    fixed_capacity_array_list_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_read_value      (o_read_value),
        .o_found_index     (o_found_index),
        .o_element_count   (o_element_count),
        .o_is_empty        (o_is_empty),
        .o_is_full         (o_is_full)
    );

    fixed_capacity_array_list_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .i_value           (i_value),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_read_value      (o_read_value),
        .i_found_index     (o_found_index),
        .i_element_count   (o_element_count),
        .i_is_empty        (o_is_empty),
        .i_is_full         (o_is_full),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results),
        .o_results_checked (results_checked),
        .o_peak_count      (peak_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: a requested long hold-off first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles without a transfer.", QUIET_LIMIT);
                $display("fixed_capacity_array_list_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // Offer one request after a random gap and return once it has been taken.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                input logic [POS_W-1:0] pos2, input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_action          <= act;
        i_position        <= pos;
        i_second_position <= pos2;
        i_value           <= val;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent_per_action[act]++;
        // Track the length roughly so that later requests stay mostly in range.
        if (act == ACT_INSERT && int'(pos) <= list_len && list_len < CAPACITY) begin
            list_len++;
            if (value_pool.size() >= POOL_DEPTH) begin
                void'(value_pool.pop_front());
            end
            value_pool.push_back(val);
        end else if (act == ACT_REMOVE && int'(pos) < list_len) begin
            list_len--;
        end
    endtask

    // Mostly random data, sometimes an extreme or a value already in the list.
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (roll < 3 && value_pool.size() > 0) begin
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        end
        return $urandom;
    endfunction

    // Mostly well-formed requests on the current list, with a little noise.
    task automatic send_random_request();
        int                roll;
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  pos2;
        logic [DATA_W-1:0] val;
        roll = $urandom_range(0, 99);
        pos  = POS_W'($urandom);
        pos2 = POS_W'($urandom);
        val  = $urandom;
        if (roll < 4) begin
            act = ACT_W'($urandom);
        end else if (roll < 34 && list_len < SMALL_LIST) begin
            act = ACT_INSERT;
            if ($urandom_range(0, 9) != 0) begin
                pos = POS_W'($urandom_range(0, list_len));
            end
            val = pick_value();
        end else if (roll < 54) begin
            act = ACT_REMOVE;
            if (list_len > 0 && $urandom_range(0, 9) != 0) begin
                pos = POS_W'($urandom_range(0, list_len - 1));
            end
        end else if (roll < 72) begin
            act = ACT_GET;
            if (list_len > 0 && $urandom_range(0, 9) != 0) begin
                pos = POS_W'($urandom_range(0, list_len - 1));
            end
        end else if (roll < 86) begin
            act = ACT_SWAP;
            if (list_len > 0 && $urandom_range(0, 9) != 0) begin
                pos  = POS_W'($urandom_range(0, list_len - 1));
                pos2 = POS_W'($urandom_range(0, list_len - 1));
            end
        end else begin
            act = ACT_FIND;
            if (value_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
                val = value_pool[$urandom_range(0, value_pool.size() - 1)];
            end else begin
                val = pick_value();
            end
        end
        send_request(act, pos, pos2, val);
    endtask

    initial begin
        int unused_codes;
        int code;
        unused_codes = 0;
        for (code = 0; code < 8; code++) begin
            sent_per_action[code] = 0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty list, edges of every action, extremes of the value.
        send_request(ACT_GET, 10'd0, 10'd0, '0);
        send_request(ACT_REMOVE, 10'd0, 10'd0, '0);
        send_request(ACT_SWAP, 10'd0, 10'd0, '0);
        send_request(ACT_FIND, 10'd0, 10'd0, '0);
        send_request(ACT_INSERT, 10'd1, 10'd0, 32'h0000_0005);
        send_request(ACT_INSERT, 10'd0, 10'd0, 32'h8000_0000);
        send_request(ACT_INSERT, 10'd1, 10'd1023, 32'h7fff_ffff);
        send_request(ACT_INSERT, 10'd0, 10'd0, '1);
        send_request(ACT_INSERT, 10'd2, 10'd0, 32'h7fff_ffff);
        send_request(ACT_GET, 10'd3, 10'd1023, '1);
        send_request(ACT_GET, 10'd4, 10'd0, '0);
        send_request(ACT_FIND, 10'd0, 10'd0, 32'h7fff_ffff);
        send_request(ACT_FIND, 10'd1023, 10'd1023, 32'h1234_5678);
        send_request(ACT_SWAP, 10'd0, 10'd3, '0);
        send_request(ACT_SWAP, 10'd2, 10'd2, '0);
        send_request(ACT_SWAP, 10'd1, 10'd1023, '0);
        send_request(ACT_SWAP, 10'd1023, 10'd1023, '0);
        send_request(ACT_GET, 10'd1023, 10'd0, '0);
        send_request(ACT_REMOVE, 10'd3, 10'd0, '0);
        send_request(ACT_REMOVE, 10'd0, 10'd0, '0);
        send_request(ACT_INSERT, 10'd1023, 10'd0, '1);
        send_request(ACT_FIND + 3'd1, POS_W'($urandom), POS_W'($urandom), $urandom);
        send_request(ACT_FIND + 3'd2, POS_W'($urandom), POS_W'($urandom), $urandom);
        send_request(ACT_LAST, '1, '1, '1);
        send_request(ACT_GET, 10'd0, 10'd0, '0);

        // Random traffic with no idling on either side.
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Hold the result side off while requests keep coming, so the block backs up.
        hold_requests++;
        repeat (10) send_random_request();
        i_in_valid <= 1'b0;
        // Let everything drain before offering more.
        while (pending_results != 0) @(negedge i_clk);

        idle_pct = 71;
        repeat (RANDOM_PER_PHASE) send_random_request();

        idle_pct  = 0;
        stall_pct = 71;
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Both sides idle now and then.
        idle_pct  = 24;
        stall_pct = 24;
        repeat (RANDOM_PER_PHASE) send_random_request();
        i_in_valid <= 1'b0;

        // Wait for the last results, then a little longer for anything stray.
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        for (code = ACT_FIND + 1; code <= ACT_LAST; code++) begin
            unused_codes += sent_per_action[code];
        end
        $display("Checked %0d results: %0d insert, %0d remove, %0d get, %0d swap,",
                 results_checked, sent_per_action[ACT_INSERT], sent_per_action[ACT_REMOVE],
                 sent_per_action[ACT_GET], sent_per_action[ACT_SWAP]);
        $display("%0d find, %0d unused code; idling none, sender, receiver, both, hold-off.",
                 sent_per_action[ACT_FIND], unused_codes);
        $display("Peak list length %0d of %0d.", peak_length, CAPACITY);
        if (fail_count == 0 && pending_results == 0) begin
            $display("fixed_capacity_array_list_unit_tb: done, clean");
        end else begin
            $display("fixed_capacity_array_list_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
